// ----- rtl/core/chih_pkg.sv -----
`default_nettype none
package chih_pkg;
    localparam int SampleWidthDef = 16;
    localparam int CordicIterDef = 16;
    localparam int AngleW = 26;
    localparam int HeadingMax = 23040;

    typedef struct packed {
        logic signed [15:0] mag_x;
        logic signed [15:0] mag_y;
        logic signed [15:0] mag_z;
        logic               restart_cal;
    } in_word_t;

    typedef struct packed {
        logic signed [15:0] corr_x;
        logic signed [15:0] corr_y;
        logic signed [15:0] corr_z;
        logic [14:0]        heading;
    } out_word_t;

    // atan(2^-i) in degrees scaled by 2^16
    function automatic logic [21:0] atan_entry(input logic [4:0] i);
        logic [21:0] r;
        begin
            case (i)
                5'd0: r = 22'd2949120;
                5'd1: r = 22'd1740967;
                5'd2: r = 22'd919879;
                5'd3: r = 22'd466945;
                5'd4: r = 22'd234379;
                5'd5: r = 22'd117304;
                5'd6: r = 22'd58666;
                5'd7: r = 22'd29335;
                5'd8: r = 22'd14668;
                5'd9: r = 22'd7334;
                5'd10: r = 22'd3667;
                5'd11: r = 22'd1833;
                5'd12: r = 22'd917;
                5'd13: r = 22'd458;
                5'd14: r = 22'd229;
                5'd15: r = 22'd115;
                5'd16: r = 22'd57;
                5'd17: r = 22'd29;
                5'd18: r = 22'd14;
                5'd19: r = 22'd7;
                5'd20: r = 22'd4;
                5'd21: r = 22'd2;
                5'd22: r = 22'd1;
                default: r = 22'd0;
            endcase
            return r;
        end
    endfunction
endpackage
`default_nettype wire

// ----- rtl/core/chih_front.sv -----
`default_nettype none
// Update extrema when calibration is enabled, compute spans and midpoints, hold one job word.
module chih_front
    import chih_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        cal_enable,
    input  wire logic        in_valid,
    output logic             in_ready,
    input  wire in_word_t    in_data,
    output logic             job_valid,
    input  wire logic        job_ready,
    output logic [16:0]      job_span_x,
    output logic [16:0]      job_span_y,
    output logic [16:0]      job_span_z,
    output logic [15:0]      job_mid_x,
    output logic [15:0]      job_mid_y,
    output logic [15:0]      job_mid_z,
    output logic [15:0]      job_s_x,
    output logic [15:0]      job_s_y,
    output logic [15:0]      job_s_z
);
    logic signed [15:0] max_reg [3];
    logic signed [15:0] min_reg [3];
    logic signed [15:0] max_next [3];
    logic signed [15:0] min_next [3];
    logic signed [15:0] smp [3];
    logic pend_reg, pend_next, full_reg;
    logic signed [16:0] sum [3];
    logic signed [16:0] half [3];
    logic [16:0] span_next [3];
    logic [16:0] span_reg [3];
    logic [15:0] mid_reg [3];
    logic [15:0] s_reg [3];
    logic acc;

    assign in_ready = !full_reg || job_ready;
    assign acc = in_valid && in_ready;
    assign smp[0] = in_data.mag_x;
    assign smp[1] = in_data.mag_y;
    assign smp[2] = in_data.mag_z;

    always_comb
    begin
        pend_next = pend_reg | in_data.restart_cal;
        for (int i = 0; i < 3; i++)
        begin
            max_next[i] = max_reg[i];
            min_next[i] = min_reg[i];
        end
        if (cal_enable)
        begin
            if (pend_next)
            begin
                for (int i = 0; i < 3; i++)
                begin
                    max_next[i] = 16'sd1;
                    min_next[i] = -16'sd1;
                end
                pend_next = 1'b0;
            end
            for (int i = 0; i < 3; i++)
            begin
                if (smp[i] > max_next[i]) max_next[i] = smp[i];
                if (smp[i] < min_next[i]) min_next[i] = smp[i];
            end
        end
        for (int i = 0; i < 3; i++)
        begin
            sum[i] = 17'(max_next[i]) + 17'(min_next[i]);
            // truncate toward zero
            half[i] = (sum[i] + 17'(sum[i][16])) >>> 1;
            span_next[i] = 17'(17'(max_next[i]) - 17'(min_next[i]));
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pend_reg <= 1'b0;
            full_reg <= 1'b0;
            for (int i = 0; i < 3; i++)
            begin
                max_reg[i] <= 16'sd1;
                min_reg[i] <= -16'sd1;
            end
        end
        else
        begin
            if (job_ready) full_reg <= 1'b0;
            if (acc)
            begin
                full_reg <= 1'b1;
                pend_reg <= pend_next;
                for (int i = 0; i < 3; i++)
                begin
                    max_reg[i] <= max_next[i];
                    min_reg[i] <= min_next[i];
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (acc)
        begin
            for (int i = 0; i < 3; i++)
            begin
                span_reg[i] <= span_next[i];
                mid_reg[i] <= half[i][15:0];
                s_reg[i] <= smp[i];
            end
        end
    end

    assign job_valid = full_reg;
    assign job_span_x = span_reg[0];
    assign job_span_y = span_reg[1];
    assign job_span_z = span_reg[2];
    assign job_mid_x = mid_reg[0];
    assign job_mid_y = mid_reg[1];
    assign job_mid_z = mid_reg[2];
    assign job_s_x = s_reg[0];
    assign job_s_y = s_reg[1];
    assign job_s_z = s_reg[2];
endmodule
`default_nettype wire

// ----- rtl/core/chih_back.sv -----
`default_nettype none
// Serial divides for the two ratios, then a serial CORDIC for the heading.
module chih_back
    import chih_pkg::*;
#(
    parameter int CORDIC_ITERATIONS = CordicIterDef
)
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        job_valid,
    output logic             job_ready,
    input  wire logic [16:0] job_span_x,
    input  wire logic [16:0] job_span_y,
    input  wire logic [16:0] job_span_z,
    input  wire logic [15:0] job_mid_x,
    input  wire logic [15:0] job_mid_y,
    input  wire logic [15:0] job_mid_z,
    input  wire logic [15:0] job_s_x,
    input  wire logic [15:0] job_s_y,
    input  wire logic [15:0] job_s_z,
    output logic             out_valid,
    input  wire logic        out_ready,
    output out_word_t        out_data
);
    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_DIV  = 3'd1;
    localparam logic [2:0] S_MUL  = 3'd2;
    localparam logic [2:0] S_PRE  = 3'd3;
    localparam logic [2:0] S_ROT  = 3'd4;
    localparam logic [2:0] S_FIN  = 3'd5;
    localparam int XW = 27;

    logic [2:0] st_reg;
    logic [4:0] cnt_reg;
    logic       ax_reg;
    logic [16:0] spx_reg, den_reg, quo_reg, rem_reg;
    logic [16:0] spy_reg, spz_reg;
    logic [15:0] mx_reg, my_reg, mz_reg, sx_reg, sy_reg, sz_reg;
    logic [15:0] ry_reg, rz_reg;
    logic [15:0] cx_reg, cy_reg, cz_reg;
    logic signed [XW-1:0] x_reg, y_reg;
    logic signed [AngleW-1:0] z_reg;
    logic        ov_reg;
    out_word_t   od_reg;
    logic [17:0] trial;
    logic [16:0] rem_sh;
    logic signed [XW-1:0] xs, ys;
    logic signed [AngleW-1:0] at, ang, rnd;
    logic [15:0] prod_y, prod_z;

    assign job_ready = (st_reg == S_IDLE);
    assign out_valid = ov_reg;
    assign out_data = od_reg;
    assign rem_sh = {rem_reg[15:0], quo_reg[16]};
    assign trial = {1'b0, rem_sh} - {1'b0, den_reg};
    assign xs = x_reg >>> cnt_reg;
    assign ys = y_reg >>> cnt_reg;
    assign at = AngleW'(atan_entry(cnt_reg));
    assign prod_y = 16'(ry_reg * sy_reg);
    assign prod_z = 16'(rz_reg * sz_reg);
    assign ang = z_reg + AngleW'(32'sd180 <<< 16);
    assign rnd = (ang + AngleW'(512)) >>> 10;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg <= S_IDLE;
            ov_reg <= 1'b0;
            cnt_reg <= '0;
            ax_reg <= 1'b0;
        end
        else
        begin
            if (out_ready) ov_reg <= 1'b0;
            case (st_reg)
                S_IDLE:
                begin
                    if (job_valid)
                    begin
                        spx_reg <= job_span_x; spy_reg <= job_span_y; spz_reg <= job_span_z;
                        mx_reg <= job_mid_x; my_reg <= job_mid_y; mz_reg <= job_mid_z;
                        sx_reg <= job_s_x; sy_reg <= job_s_y; sz_reg <= job_s_z;
                        quo_reg <= job_span_x;
                        rem_reg <= '0;
                        den_reg <= job_span_y;
                        ax_reg <= 1'b0;
                        cnt_reg <= '0;
                        st_reg <= S_DIV;
                    end
                end
                S_DIV:
                begin
                    // one quotient bit per cycle, restoring
                    if (!trial[17])
                    begin
                        rem_reg <= trial[16:0];
                        quo_reg <= {quo_reg[15:0], 1'b1};
                    end
                    else
                    begin
                        rem_reg <= rem_sh;
                        quo_reg <= {quo_reg[15:0], 1'b0};
                    end
                    cnt_reg <= cnt_reg + 5'd1;
                    if (cnt_reg == 5'd16)
                    begin
                        cnt_reg <= '0;
                        if (!ax_reg)
                        begin
                            ry_reg <= (!trial[17]) ? {quo_reg[14:0], 1'b1}
                                                   : {quo_reg[14:0], 1'b0};
                            ax_reg <= 1'b1;
                            quo_reg <= spx_reg;
                            rem_reg <= '0;
                            den_reg <= spz_reg;
                        end
                        else
                        begin
                            rz_reg <= (!trial[17]) ? {quo_reg[14:0], 1'b1}
                                                   : {quo_reg[14:0], 1'b0};
                            st_reg <= S_MUL;
                        end
                    end
                end
                S_MUL:
                begin
                    cx_reg <= sx_reg - mx_reg;
                    cy_reg <= prod_y - my_reg;
                    cz_reg <= prod_z - mz_reg;
                    st_reg <= S_PRE;
                end
                S_PRE:
                begin
                    z_reg <= '0;
                    cnt_reg <= '0;
                    if (cx_reg[15])
                    begin
                        x_reg <= -(XW'($signed(cx_reg)) <<< 8);
                        y_reg <= -(XW'($signed(cy_reg)) <<< 8);
                        z_reg <= cy_reg[15] ? -AngleW'(32'sd180 <<< 16)
                                            : AngleW'(32'sd180 <<< 16);
                    end
                    else
                    begin
                        x_reg <= XW'($signed(cx_reg)) <<< 8;
                        y_reg <= XW'($signed(cy_reg)) <<< 8;
                    end
                    st_reg <= S_ROT;
                end
                S_ROT:
                begin
                    if (!y_reg[XW-1])
                    begin
                        x_reg <= x_reg + ys;
                        y_reg <= y_reg - xs;
                        z_reg <= z_reg + at;
                    end
                    else
                    begin
                        x_reg <= x_reg - ys;
                        y_reg <= y_reg + xs;
                        z_reg <= z_reg - at;
                    end
                    cnt_reg <= cnt_reg + 5'd1;
                    if (cnt_reg == 5'(CORDIC_ITERATIONS - 1)) st_reg <= S_FIN;
                end
                S_FIN:
                begin
                    if (!ov_reg || out_ready)
                    begin
                        od_reg.corr_x <= cx_reg;
                        od_reg.corr_y <= cy_reg;
                        od_reg.corr_z <= cz_reg;
                        if (ang[AngleW-1])
                            od_reg.heading <= '0;
                        else if (rnd > AngleW'(HeadingMax))
                            od_reg.heading <= 15'(HeadingMax);
                        else
                            od_reg.heading <= rnd[14:0];
                        ov_reg <= 1'b1;
                        st_reg <= S_IDLE;
                    end
                end
                default: st_reg <= S_IDLE;
            endcase
        end
    end
endmodule
`default_nettype wire

// ----- rtl/core/compass_hard_iron_heading.sv -----
`default_nettype none
// Hard-iron compass correction with heading. Each accepted word of three
// signed 16-bit axis samples yields one word: x minus its midpoint, y and z
// scaled by the integer span ratio to x then offset, and a heading of
// atan2(y, x)+180 degrees in 1/64 degree steps. A front stage updates the
// extrema in the accept cycle and holds one job; the back end loads the job,
// runs two serial divides, a multiply state, a setup state, the CORDIC
// rotations and an output state, and takes no new job until it is back in
// idle, so throughput is set by the back end's divider and CORDIC loop. A
// stalled output holds the back end in its output state until the previous
// word is taken.
// cal_enable is written through cfg_we/cfg_data and resets to 1.
module compass_hard_iron_heading
    import chih_pkg::*;
#(
    parameter int CORDIC_ITERATIONS = CordicIterDef
)
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire logic      cfg_we,
    input  wire logic      cfg_data,
    input  wire logic      in_valid,
    output logic           in_ready,
    input  wire in_word_t  in_data,
    output logic           out_valid,
    input  wire logic      out_ready,
    output out_word_t      out_data
);
    logic cal_reg;
    logic jv, jr;
    logic [16:0] spx, spy, spz;
    logic [15:0] mx, my, mz, sx, sy, sz;

    // hold the calibration enable
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            cal_reg <= 1'b1;
        else if (cfg_we)
            cal_reg <= cfg_data;
    end

    chih_front u_front (
        .clk(clk), .rst_n(rst_n), .cal_enable(cal_reg),
        .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
        .job_valid(jv), .job_ready(jr),
        .job_span_x(spx), .job_span_y(spy), .job_span_z(spz),
        .job_mid_x(mx), .job_mid_y(my), .job_mid_z(mz),
        .job_s_x(sx), .job_s_y(sy), .job_s_z(sz)
    );

    chih_back #(.CORDIC_ITERATIONS(CORDIC_ITERATIONS)) u_back (
        .clk(clk), .rst_n(rst_n),
        .job_valid(jv), .job_ready(jr),
        .job_span_x(spx), .job_span_y(spy), .job_span_z(spz),
        .job_mid_x(mx), .job_mid_y(my), .job_mid_z(mz),
        .job_s_x(sx), .job_s_y(sy), .job_s_z(sz),
        .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data)
    );
endmodule
`default_nettype wire

// ----- rtl/core/chih_checker.sv -----
`default_nettype none
module chih_checker
    import chih_pkg::*;
(
    input wire logic      clk,
    input wire logic      rst_n,
    input wire logic      out_valid,
    input wire logic      out_ready,
    input wire out_word_t out_data
);
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_data))
        else $error("output word changed while stalled");
    a_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> out_data.heading <= 15'd23040)
        else $error("heading out of range");
    a_known: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> !$isunknown(out_data))
        else $error("output word has unknown bits");
endmodule

bind compass_hard_iron_heading chih_checker u_chk (
    .clk(clk), .rst_n(rst_n), .out_valid(out_valid),
    .out_ready(out_ready), .out_data(out_data)
);
`default_nettype wire
